>>> hw/rtl/morphological_skeleton_core_assert.svh
// Assertion macros shared by the skeleton core
`ifndef MORPHOLOGICAL_SKELETON_CORE_ASSERT_SVH
`define MORPHOLOGICAL_SKELETON_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define MSK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define MSK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/msk_pkg.sv
`default_nettype none
package msk_pkg;
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 9;
    localparam int DEF_MAX_W  = 256;
    localparam int DEF_MAX_H  = 256;
    localparam int PASS_LIMIT = 255;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    function automatic int clamp_dim(logic [CFG_W-1:0] v, int maxv);
        int r;
        r = int'(v);
        if (r < 1) r = 1;
        if (r > maxv) r = maxv;
        return r;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/msk_ram.sv
`default_nettype none
module msk_ram #(
    parameter int AW = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire  [AW-1:0]           i_waddr,
    input  wire  msk_pkg::t_pix     i_wdata,
    input  wire  [AW-1:0]           i_raddr,
    output msk_pkg::t_pix           o_rdata
);
    msk_pkg::t_pix r_mem [2**AW];
    msk_pkg::t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> hw/rtl/msk_alu.sv
`default_nettype none
module msk_alu (
    input  wire              i_max,
    input  wire  msk_pkg::t_pix i_a,
    input  wire  msk_pkg::t_pix i_b,
    output msk_pkg::t_pix    o_y
);
    logic w_b_gt;

    assign w_b_gt = i_b > i_a;
    assign o_y    = (w_b_gt == i_max) ? i_b : i_a;
endmodule
`default_nettype wire

>>> hw/rtl/morphological_skeleton_core.sv
// Grey-level morphological skeleton with a 3x3 cross. Kind 0 transfers load source pixels,
// kind 2 transfers read skeleton pixels (one result each), kind 1 starts a run that answers
// one result with done_res set and the pass count. A run first sweeps the skeleton store, one
// entry a cycle over all 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries, then each pass
// runs erosion and opening, which read five neighbours one per cycle through the single read
// port of their store and a shared min/max unit, then copies the eroded image into the work
// store pixel by pixel. Reads before the first run answer zero.
// The block takes no transfer while a run or a read is in progress.
`default_nettype none
`include "morphological_skeleton_core_assert.svh"
module morphological_skeleton_core #(
    parameter int MAX_WIDTH  = msk_pkg::DEF_MAX_W,
    parameter int MAX_HEIGHT = msk_pkg::DEF_MAX_H
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // col, row, pixel_in
    input  wire  [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pixel_out, pass_count
    output logic [0:0]  m_axis_tuser,   // done_res
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [msk_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = CW + RW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CLR  = 3'd2;
    localparam logic [2:0] ST_ERO  = 3'd3;
    localparam logic [2:0] ST_OPN  = 3'd4;
    localparam logic [2:0] ST_CPY  = 3'd5;

    logic [2:0]  r_state;
    logic [msk_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [CW-1:0] r_c;
    logic [RW-1:0] r_r;
    logic [2:0]  r_step;
    logic [AW-1:0] r_clr;
    logic [7:0]  r_pass;
    logic        r_more, r_skok, r_rd_zero;
    msk_pkg::t_pix r_acc, r_src, r_skv;
    logic        r_ov, r_done;
    msk_pkg::t_pix r_pix;
    logic [7:0]  r_pcnt;

    int          w, h;
    logic        in_acc, in_range, last_col, last_row;
    logic [4:0]  nb_ok;
    logic [AW-1:0] ctr_addr, nb_addr, in_addr;
    logic [1:0]  kind;
    logic [7:0]  in_col, in_row;
    msk_pkg::t_pix in_pix;
    msk_pkg::t_pix work_rd, ero_rd, skel_rd, cur_rd, alu_y, res, skel_new;
    logic        work_we, ero_we, skel_we;
    logic [AW-1:0] work_wa, work_ra, ero_ra, skel_wa, skel_ra;
    msk_pkg::t_pix work_wd, skel_wd;

    assign kind   = s_axis_tuser;
    assign in_col = s_axis_tdata[7:0];
    assign in_row = s_axis_tdata[15:8];
    assign in_pix = s_axis_tdata[23:16];

    assign w = msk_pkg::clamp_dim(r_cfg_w, MAX_WIDTH);
    assign h = msk_pkg::clamp_dim(r_cfg_h, MAX_HEIGHT);

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ov || m_axis_tready);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_range = (int'(in_col) < w) && (int'(in_row) < h);
    assign in_addr  = {RW'(in_row), CW'(in_col)};

    assign last_col = int'(r_c) == w - 1;
    assign last_row = int'(r_r) == h - 1;
    assign ctr_addr = {r_r, r_c};
    assign nb_ok    = {!last_col, r_c != '0, !last_row, r_r != '0, 1'b1};

    always_comb begin
        unique case (r_step)
            3'd1:    nb_addr = {r_r - 1'b1, r_c};
            3'd2:    nb_addr = {r_r + 1'b1, r_c};
            3'd3:    nb_addr = {r_r, r_c - 1'b1};
            3'd4:    nb_addr = {r_r, r_c + 1'b1};
            default: nb_addr = ctr_addr;
        endcase
    end

    assign cur_rd = (r_state == ST_OPN) ? ero_rd : work_rd;

    msk_alu u_alu (
        .i_max (r_state == ST_OPN),
        .i_a   (r_acc),
        .i_b   (cur_rd),
        .o_y   (alu_y)
    );

    assign res      = nb_ok[4] ? alu_y : r_acc;
    assign skel_new = r_skv | (r_src - res);

    assign work_ra = (r_state == ST_ERO) ? nb_addr : ctr_addr;
    assign ero_ra  = (r_state == ST_OPN) ? nb_addr : ctr_addr;
    assign skel_ra = (r_state == ST_IDLE) ? in_addr : ctr_addr;

    assign work_we = (in_acc && kind == msk_pkg::KIND_WRITE && in_range)
                   || (r_state == ST_CPY && r_step == 3'd1);
    assign work_wa = (r_state == ST_CPY) ? ctr_addr : in_addr;
    assign work_wd = (r_state == ST_CPY) ? ero_rd : in_pix;

    assign ero_we  = (r_state == ST_ERO) && (r_step == 3'd5);

    assign skel_we = (r_state == ST_CLR)
                   || (r_state == ST_OPN && r_step == 3'd5 && r_src > res);
    assign skel_wa = (r_state == ST_CLR) ? r_clr : ctr_addr;
    assign skel_wd = (r_state == ST_CLR) ? '0 : skel_new;

    msk_ram #(.AW(AW)) u_work (
        .i_clk (i_clk), .i_we (work_we), .i_waddr (work_wa), .i_wdata (work_wd),
        .i_raddr (work_ra), .o_rdata (work_rd)
    );
    msk_ram #(.AW(AW)) u_ero (
        .i_clk (i_clk), .i_we (ero_we), .i_waddr (ctr_addr), .i_wdata (res),
        .i_raddr (ero_ra), .o_rdata (ero_rd)
    );
    msk_ram #(.AW(AW)) u_skel (
        .i_clk (i_clk), .i_we (skel_we), .i_waddr (skel_wa), .i_wdata (skel_wd),
        .i_raddr (skel_ra), .o_rdata (skel_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cfg_w <= msk_pkg::CFG_W'(256);
            r_cfg_h <= msk_pkg::CFG_W'(256);
            r_ov    <= 1'b0;
            r_skok  <= 1'b0;
            r_step  <= '0;
            r_pass  <= '0;
            r_more  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    msk_pkg::CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_data;
                    msk_pkg::CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state) inside
                ST_IDLE: begin
                    if (m_axis_tready) begin
                        r_ov <= 1'b0;
                    end
                    if (in_acc) begin
                        unique case (kind)
                            msk_pkg::KIND_RUN: begin
                                r_state <= ST_CLR;
                                r_clr   <= '0;
                                r_pass  <= '0;
                            end
                            msk_pkg::KIND_READ: begin
                                r_state   <= ST_RD;
                                r_rd_zero <= !(in_range && r_skok);
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RD: begin
                    r_ov    <= 1'b1;
                    r_pix   <= r_rd_zero ? '0 : skel_rd;
                    r_done  <= 1'b0;
                    r_pcnt  <= '0;
                    r_state <= ST_IDLE;
                end
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_skok  <= 1'b1;
                        r_state <= ST_ERO;
                        r_r     <= '0;
                        r_c     <= '0;
                        r_step  <= '0;
                        r_more  <= 1'b0;
                    end
                end
                ST_ERO, ST_OPN: begin
                    r_step <= (r_step == 3'd5) ? 3'd0 : r_step + 1'b1;
                    if (r_step == 3'd1) begin
                        r_acc <= cur_rd;
                        r_src <= work_rd;
                        r_skv <= skel_rd;
                    end else if (r_step >= 3'd2 && r_step <= 3'd4 && nb_ok[r_step-3'd1]) begin
                        r_acc <= alu_y;
                    end
                    if (r_step == 3'd5) begin
                        if (r_state == ST_OPN && res != '0) begin
                            r_more <= 1'b1;
                        end
                        if (last_col) begin
                            r_c <= '0;
                            r_r <= last_row ? '0 : r_r + 1'b1;
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                        if (last_col && last_row) begin
                            r_state <= (r_state == ST_ERO) ? ST_OPN : ST_CPY;
                        end
                    end
                end
                ST_CPY: begin
                    r_step <= {2'b00, ~r_step[0]};
                    if (r_step[0]) begin
                        if (last_col) begin
                            r_c <= '0;
                            r_r <= last_row ? '0 : r_r + 1'b1;
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                        if (last_col && last_row) begin
                            r_pass <= r_pass + 1'b1;
                            if (r_more && int'(r_pass) + 1 < msk_pkg::PASS_LIMIT) begin
                                r_state <= ST_ERO;
                                r_more  <= 1'b0;
                            end else begin
                                r_state <= ST_IDLE;
                                r_ov    <= 1'b1;
                                r_pix   <= '0;
                                r_done  <= 1'b1;
                                r_pcnt  <= r_pass + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_pcnt, r_pix};
    assign m_axis_tuser  = r_done;

    `MSK_ASSERT_NOW(a_ready_idle, s_axis_tready, r_state == ST_IDLE)
    `MSK_ASSERT_NEXT(a_read_seq, in_acc && kind == msk_pkg::KIND_READ, r_state == ST_RD)
    `MSK_ASSERT_NOW(a_step_range, r_state == ST_ERO || r_state == ST_OPN, r_step <= 3'd5)
    `MSK_ASSERT_NOW(a_done_count, r_ov && r_done, r_pcnt != 8'd0)
endmodule
`default_nettype wire

>>> tb/morphological_skeleton_core_tb.sv
`default_nettype none
module morphological_skeleton_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int STORE = 65536;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] pix;
    } t_req;

    typedef struct packed {
        logic [7:0] pix;
        logic       done;
        logic [7:0] passes;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [msk_pkg::CFG_W-1:0] i_cfg_data;

    morphological_skeleton_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    t_req    pending_reqs[$];
    t_answer expected_answers[$];
    int      mismatches;

    logic [7:0] work_img[STORE];
    logic [7:0] eroded_img[STORE];
    logic [7:0] skel_img[STORE];
    bit         loaded[STORE];
    logic [msk_pkg::CFG_W-1:0] width_reg;
    logic [msk_pkg::CFG_W-1:0] height_reg;

    bit stall_req;
    bit stall_taken;
    int hold_left;
    int cyc;
    int burst_left;
    int gap_left;

    always #4 i_clk = ~i_clk;

    function automatic int dim_of(logic [msk_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    function automatic int addr(int r, int c);
        return r * 256 + c;
    endfunction

    function automatic bit skeleton_pass(int w, int h);
        bit nonzero;
        logic [7:0] m;
        logic [7:0] src;
        nonzero = 0;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++) begin
                m = work_img[addr(r, c)];
                if (r > 0 && work_img[addr(r - 1, c)] < m) m = work_img[addr(r - 1, c)];
                if (r + 1 < h && work_img[addr(r + 1, c)] < m) m = work_img[addr(r + 1, c)];
                if (c > 0 && work_img[addr(r, c - 1)] < m) m = work_img[addr(r, c - 1)];
                if (c + 1 < w && work_img[addr(r, c + 1)] < m) m = work_img[addr(r, c + 1)];
                eroded_img[addr(r, c)] = m;
            end
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++) begin
                m = eroded_img[addr(r, c)];
                src = work_img[addr(r, c)];
                if (r > 0 && eroded_img[addr(r - 1, c)] > m) m = eroded_img[addr(r - 1, c)];
                if (r + 1 < h && eroded_img[addr(r + 1, c)] > m) m = eroded_img[addr(r + 1, c)];
                if (c > 0 && eroded_img[addr(r, c - 1)] > m) m = eroded_img[addr(r, c - 1)];
                if (c + 1 < w && eroded_img[addr(r, c + 1)] > m) m = eroded_img[addr(r, c + 1)];
                if (m != 0) nonzero = 1;
                if (src > m) skel_img[addr(r, c)] |= src - m;
            end
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                work_img[addr(r, c)] = eroded_img[addr(r, c)];
        return nonzero;
    endfunction

    task automatic predict_transfer(t_req q);
        int w;
        int h;
        bit more;
        logic [7:0] count;
        t_answer a;
        w = dim_of(width_reg);
        h = dim_of(height_reg);
        case (q.kind)
            msk_pkg::KIND_WRITE: begin
                if (q.col < w && q.row < h) work_img[addr(q.row, q.col)] = q.pix;
            end
            msk_pkg::KIND_RUN: begin
                for (int i = 0; i < STORE; i++) skel_img[i] = 0;
                count = 0;
                do begin
                    more = skeleton_pass(w, h);
                    count++;
                end while (more && count < msk_pkg::PASS_LIMIT);
                a = '{pix: 8'd0, done: 1'b1, passes: count};
                expected_answers = {expected_answers, a};
            end
            msk_pkg::KIND_READ: begin
                a.pix = (q.col < w && q.row < h) ? skel_img[addr(q.row, q.col)] : 8'd0;
                a.done = 0;
                a.passes = 0;
                expected_answers = {expected_answers, a};
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // driver: bursts with random gaps, valid held until transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_transfer(pending_reqs[0]);
                void'(pending_reqs.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 0;
                end else if (pending_reqs.size() > 0) begin
                    s_axis_tvalid <= 1;
                    s_axis_tdata <= {pending_reqs[0].pix, pending_reqs[0].row,
                                     pending_reqs[0].col};
                    s_axis_tuser <= pending_reqs[0].kind;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 0;
                end
            end
        end
    end

    // receiver: random stalls, free stretches, one long hold-off on request
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (stall_req && !stall_taken) begin
            stall_taken <= 1;
            hold_left <= 3000;
            m_axis_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 0;
        end else if (cyc % 1024 < 200) begin
            m_axis_tready <= 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_answers.size() == 0) begin
                report("unexpected result", m_axis_tdata, 16'd0);
            end else begin
                e = expected_answers.pop_front();
                if (m_axis_tdata[7:0] !== e.pix)
                    report("pixel_out", 16'(m_axis_tdata[7:0]), 16'(e.pix));
                if (m_axis_tuser[0] !== e.done)
                    report("done_res", 16'(m_axis_tuser[0]), 16'(e.done));
                if (m_axis_tdata[15:8] !== e.passes)
                    report("pass_count", 16'(m_axis_tdata[15:8]), 16'(e.passes));
            end
        end
    end

    function automatic logic [7:0] rand_pix();
        return ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_req(logic [1:0] k, logic [7:0] c, logic [7:0] r, logic [7:0] p);
        t_req q;
        q = '{kind: k, col: c, row: r, pix: p};
        if (k == msk_pkg::KIND_WRITE && c < dim_of(width_reg) && r < dim_of(height_reg))
            loaded[addr(r, c)] = 1;
        pending_reqs = {pending_reqs, q};
    endtask

    task automatic fill_area(bit only_missing);
        for (int r = 0; r < dim_of(height_reg); r++)
            for (int c = 0; c < dim_of(width_reg); c++)
                if (!only_missing || !loaded[addr(r, c)])
                    queue_req(msk_pkg::KIND_WRITE, 8'(c), 8'(r), rand_pix());
    endtask

    task automatic queue_run();
        fill_area(1);
        queue_req(msk_pkg::KIND_RUN, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic queue_mix(int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                if ($urandom_range(0, 3) != 0)
                    queue_req(msk_pkg::KIND_WRITE,
                              8'($urandom_range(0, dim_of(width_reg) - 1)),
                              8'($urandom_range(0, dim_of(height_reg) - 1)), rand_pix());
                else
                    queue_req(msk_pkg::KIND_WRITE, 8'($urandom), 8'($urandom),
                              8'($urandom));
            end else if (sel < 9) begin
                if ($urandom_range(0, 3) != 0)
                    queue_req(msk_pkg::KIND_READ, 8'($urandom_range(0, dim_of(width_reg))),
                              8'($urandom_range(0, dim_of(height_reg))), 8'($urandom));
                else
                    queue_req(msk_pkg::KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                queue_req(KIND_NONE, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [msk_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == msk_pkg::CFG_IDX_WIDTH) width_reg = val;
        else height_reg = val;
    endtask

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        m_axis_tready = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        mismatches = 0;
        stall_req = 0;
        stall_taken = 0;
        hold_left = 0;
        cyc = 0;
        burst_left = 1;
        gap_left = 0;
        width_reg = 256;
        height_reg = 256;
        for (int i = 0; i < STORE; i++) begin
            work_img[i] = 0;
            eroded_img[i] = 0;
            skel_img[i] = 0;
            loaded[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // reads before any run, corner writes, ignored kind
        queue_req(msk_pkg::KIND_READ, 8'd255, 8'd255, 8'd0);
        queue_req(msk_pkg::KIND_WRITE, 8'd255, 8'd255, 8'd255);
        queue_req(msk_pkg::KIND_WRITE, 8'd0, 8'd0, 8'd0);
        queue_req(KIND_NONE, 8'd255, 8'd255, 8'd255);
        queue_req(msk_pkg::KIND_READ, 8'd0, 8'd0, 8'd255);
        wait_idle();

        // zero dimensions act as 1x1; nonzero pixel never erodes away
        cfg_write(msk_pkg::CFG_IDX_WIDTH, 9'd0);
        cfg_write(msk_pkg::CFG_IDX_HEIGHT, 9'd0);
        queue_req(msk_pkg::KIND_WRITE, 8'd0, 8'd0, 8'd200);
        queue_req(msk_pkg::KIND_WRITE, 8'd1, 8'd0, 8'd7);
        queue_run();
        queue_req(msk_pkg::KIND_READ, 8'd0, 8'd0, 8'd0);
        queue_req(msk_pkg::KIND_READ, 8'd1, 8'd0, 8'd0);
        queue_req(msk_pkg::KIND_READ, 8'd0, 8'd1, 8'd0);
        queue_run();
        queue_req(msk_pkg::KIND_READ, 8'd0, 8'd0, 8'd0);
        wait_idle();

        // oversized width clamps to full row
        cfg_write(msk_pkg::CFG_IDX_WIDTH, 9'd511);
        cfg_write(msk_pkg::CFG_IDX_HEIGHT, 9'd1);
        fill_area(0);
        queue_run();
        queue_mix(10);
        wait_idle();

        cfg_write(msk_pkg::CFG_IDX_WIDTH, 9'd1);
        cfg_write(msk_pkg::CFG_IDX_HEIGHT, 9'd256);
        fill_area(0);
        queue_run();
        queue_mix(10);
        wait_idle();

        for (int ph = 0; ph < 3; ph++) begin
            cfg_write(msk_pkg::CFG_IDX_WIDTH, 9'($urandom_range(1, 10)));
            cfg_write(msk_pkg::CFG_IDX_HEIGHT, 9'($urandom_range(1, 10)));
            if ($urandom_range(0, 1) == 0) fill_area(0);
            queue_mix(15);
            queue_run();
            if (ph == 2) stall_req = 1;
            queue_mix(20);
            if ($urandom_range(0, 1) == 0) begin
                queue_run();
                queue_mix(10);
            end
            wait_idle();
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(500_000_000);
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

>>> morphological_skeleton_core.f
+incdir+hw/rtl
hw/rtl/msk_pkg.sv
hw/rtl/msk_ram.sv
hw/rtl/msk_alu.sv
hw/rtl/morphological_skeleton_core.sv
tb/morphological_skeleton_core_tb.sv
